// File: hw/rtl/coc_pkg.sv
`default_nettype none
package coc_pkg;

  localparam int RESP_W     = 16;
  localparam int DIRECTIONS = 9;
  localparam int DIR_W      = 4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register word index, taken from paddr[2]
  localparam logic REG_DIRECTIONS_IN_USE = 1'b0;
  localparam logic [DIR_W-1:0] DIRS_RESET = DIR_W'(DIRECTIONS);

  typedef logic signed [RESP_W-1:0] resp_t;
  typedef resp_t resp_vec_t [DIRECTIONS];

  typedef struct packed {
    resp_t            top;
    logic [DIR_W-1:0] win;
    logic             side;
  } scale_best_t;

endpackage
`default_nettype wire

// File: hw/rtl/coc_cfg.sv
`default_nettype none
module coc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [coc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [coc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [coc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output logic      [coc_pkg::DIR_W-1:0]        dirs_cfg
);

  logic [coc_pkg::DIR_W-1:0] dirs_r;
  logic [coc_pkg::DIR_W-1:0] dirs_nxt;
  logic                      hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == coc_pkg::REG_DIRECTIONS_IN_USE);

  always_comb begin
    dirs_nxt = dirs_r;
    if (psel && penable && pwrite && hit) begin
      dirs_nxt = pwdata[coc_pkg::DIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirs_r <= coc_pkg::DIRS_RESET;
    end else begin
      dirs_r <= dirs_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = coc_pkg::CFG_DATA_W'(dirs_r);
    end
  end

  assign dirs_cfg = dirs_r;

endmodule
`default_nettype wire

// File: hw/rtl/coc_argmax.sv
`default_nettype none
module coc_argmax (
  input  wire coc_pkg::resp_vec_t            resp,
  input  wire logic [coc_pkg::DIR_W-1:0]     dirs_cfg,
  output coc_pkg::scale_best_t               best
);

  logic [coc_pkg::DIR_W-1:0]       n_eff;
  logic [coc_pkg::DIR_W-1:0]       n_m1;
  coc_pkg::resp_t                  top;
  logic [coc_pkg::DIR_W-1:0]       win;
  coc_pkg::resp_t                  r_last;
  logic [coc_pkg::DIRECTIONS-1:0]  side_vec;
  logic                            side;

  // clamp lane count to 1..DIRECTIONS
  always_comb begin
    n_eff = dirs_cfg;
    if (dirs_cfg == '0) begin
      n_eff = coc_pkg::DIR_W'(1);
    end else if (dirs_cfg > coc_pkg::DIR_W'(coc_pkg::DIRECTIONS)) begin
      n_eff = coc_pkg::DIR_W'(coc_pkg::DIRECTIONS);
    end
  end

  assign n_m1 = n_eff - coc_pkg::DIR_W'(1);

  // first lane wins ties: update only on strictly greater
  always_comb begin
    top = resp[0];
    win = '0;
    for (int d = 1; d < coc_pkg::DIRECTIONS; d++) begin
      if ((coc_pkg::DIR_W'(d) < n_eff) && (resp[d] > top)) begin
        top = resp[d];
        win = coc_pkg::DIR_W'(d);
      end
    end
  end

  // wrap value for the right neighbor of lane 0
  always_comb begin
    r_last = resp[0];
    for (int d = 0; d < coc_pkg::DIRECTIONS; d++) begin
      if (coc_pkg::DIR_W'(d) == n_m1) begin
        r_last = resp[d];
      end
    end
  end

  // side bit for every lane as a candidate winner
  always_comb begin
    for (int d = 0; d < coc_pkg::DIRECTIONS; d++) begin
      coc_pkg::resp_t lv;
      coc_pkg::resp_t rv;
      lv = (coc_pkg::DIR_W'(d + 1) >= n_eff) ? resp[0]
                                              : resp[(d + 1) % coc_pkg::DIRECTIONS];
      rv = (d == 0) ? r_last
                    : resp[(d + coc_pkg::DIRECTIONS - 1) % coc_pkg::DIRECTIONS];
      side_vec[d] = (lv >= rv);
    end
  end

  always_comb begin
    side = side_vec[0];
    for (int d = 1; d < coc_pkg::DIRECTIONS; d++) begin
      if (win == coc_pkg::DIR_W'(d)) begin
        side = side_vec[d];
      end
    end
  end

  assign best.top  = top;
  assign best.win  = win;
  assign best.side = side;

endmodule
`default_nettype wire

// File: hw/rtl/competitive_orientation_coder_unit.sv
`default_nettype none
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_resp_dir0..8 (s16), in_last_scale
// out_      output     out_valid/out_stall out_max_response (s16),
//                                          out_direction_code (4), out_side_code
// cfg (APB) input      psel/penable/pready directions_in_use at byte address 0
//
// One transfer per clock sustained while in_stall is low. While an item sits in the input
// register, the per-scale maximum, winner and side bit are formed from it and
// folded into the running pixel best as it advances. An item marked last_scale
// is loaded into the output register as it leaves the input register.
// Reset (rst_n low, synchronous) empties both stages, clears the pixel state
// and sets directions_in_use to 9. in_stall rises only while a last-scale item
// is held behind a stalled, occupied output register.
module competitive_orientation_coder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [15:0]              in_resp_dir0,
  input  wire logic signed [15:0]              in_resp_dir1,
  input  wire logic signed [15:0]              in_resp_dir2,
  input  wire logic signed [15:0]              in_resp_dir3,
  input  wire logic signed [15:0]              in_resp_dir4,
  input  wire logic signed [15:0]              in_resp_dir5,
  input  wire logic signed [15:0]              in_resp_dir6,
  input  wire logic signed [15:0]              in_resp_dir7,
  input  wire logic signed [15:0]              in_resp_dir8,
  input  wire logic                            in_last_scale,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [15:0]                   out_max_response,
  output logic        [3:0]                    out_direction_code,
  output logic                                 out_side_code,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [coc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [coc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [coc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  logic [coc_pkg::DIR_W-1:0]  dirs_cfg;

  // input register
  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  coc_pkg::resp_vec_t         s1_resp_r;
  logic                       s1_last_r;
  logic                       in_xfer;
  logic                       s1_adv;

  // running pixel state
  coc_pkg::resp_t             best_resp_r;
  logic [coc_pkg::DIR_W-1:0]  best_dir_r;
  logic                       best_side_r;
  logic                       started_r;
  logic                       started_nxt;
  coc_pkg::scale_best_t       scale_best;
  coc_pkg::scale_best_t       merged;
  logic                       take_scale;

  // output register
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       out_load;
  coc_pkg::scale_best_t       out_r;

  coc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .dirs_cfg (dirs_cfg)
  );

  coc_argmax u_argmax (
    .resp     (s1_resp_r),
    .dirs_cfg (dirs_cfg),
    .best     (scale_best)
  );

  // A non-last item never needs the output register, so it always advances.
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // hold payload until a new transfer lands
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_resp_r[0] <= in_resp_dir0;
      s1_resp_r[1] <= in_resp_dir1;
      s1_resp_r[2] <= in_resp_dir2;
      s1_resp_r[3] <= in_resp_dir3;
      s1_resp_r[4] <= in_resp_dir4;
      s1_resp_r[5] <= in_resp_dir5;
      s1_resp_r[6] <= in_resp_dir6;
      s1_resp_r[7] <= in_resp_dir7;
      s1_resp_r[8] <= in_resp_dir8;
      s1_last_r    <= in_last_scale;
    end
  end

  // First scale of a pixel always wins; later scales only on strictly greater,
  // so ties stay with the earlier scale.
  assign take_scale = !started_r || (scale_best.top > best_resp_r);

  always_comb begin
    merged.top  = best_resp_r;
    merged.win  = best_dir_r;
    merged.side = best_side_r;
    if (take_scale) begin
      merged = scale_best;
    end
  end

  always_comb begin
    started_nxt = started_r;
    if (s1_adv) begin
      started_nxt = !s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      best_resp_r <= '0;
      best_dir_r  <= '0;
      best_side_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
      if (s1_adv) begin
        best_resp_r <= merged.top;
        best_dir_r  <= merged.win;
        best_side_r <= merged.side;
      end
    end
  end

  // output register: load on a last-scale advance, drop once taken
  assign out_load = s1_adv && s1_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= merged;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_max_response   = out_r.top;
  assign out_direction_code = out_r.win;
  assign out_side_code      = out_r.side;

endmodule
`default_nettype wire
